/* src/lqar_pkg.sv */
// Package for the linked queue block: sizes, link encoding, RAM write port type.
// No dependencies; imported by lqar_link_ram and linked_queue_append_remove.
package lqar_pkg;

    localparam int CAPACITY = 64;
    localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LINK_W   = $clog2(CAPACITY) + 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = 6;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CAPACITY);

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] addr;
        logic [LINK_W-1:0] data;
    } lqar_wr_t;

    function automatic logic slot_ok(input logic [LINK_W-1:0] s);
        return s < NULL_LINK;
    endfunction

endpackage

/* src/lqar_link_ram.sv */
// Next-link store: CAPACITY entries, one write port, one read port, registered read.
// Depends on lqar_pkg.
module lqar_link_ram
    import lqar_pkg::*;
(
    input  logic              aclk,
    input  lqar_wr_t          wr,
    input  logic [SLOT_W-1:0] rd_addr,
    output logic [LINK_W-1:0] rd_data
);

    logic [LINK_W-1:0] mem [CAPACITY];
    logic [LINK_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/linked_queue_append_remove.sv */
// Linked queue with append at tail and remove of any element; head and tail in registers.
// Depends on lqar_pkg and lqar_link_ram.
//
//  channel | dir | ports                              | word
//  --------+-----+------------------------------------+----------------------------------
//  s_      | in  | s_tvalid s_tready s_tdata s_tuser  | func, element_index
//  m_      | out | m_tvalid m_tready m_tdata          | status, queue_empty, head_index
//
// One word at a time; s_tready is high only while the sequencer is idle.
// Append nulls the element's link, then links the old tail to it unless queue or tail is empty.
// Remove answers at once on an empty queue, unlinks the head on a head hit, else walks:
// the walk reads one link per cycle from the link RAM read port.
// Reset clears head and tail to null; the link RAM is not cleared.
// A new word is accepted while a result waits; the next result waits for m_tready.
module linked_queue_append_remove
    import lqar_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [5:0] element_index, [7:6] zero
    input  logic       s_tuser,   // [0] func
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] status, [1] queue_empty, [7:2] head_index
);

    localparam logic FUNC_APPEND = 1'b0;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_APP1  = 4'd1;
    localparam logic [3:0] ST_APP2  = 4'd2;
    localparam logic [3:0] ST_HREAD = 4'd3;
    localparam logic [3:0] ST_WALK  = 4'd4;
    localparam logic [3:0] ST_FIX   = 4'd5;
    localparam logic [3:0] ST_FIX2  = 4'd6;
    localparam logic [3:0] ST_RESP  = 4'd7;

    logic [3:0]        state_reg, state_next;
    logic [LINK_W-1:0] head_reg, head_next;
    logic [LINK_W-1:0] tail_reg, tail_next;
    logic [LINK_W-1:0] elem_reg, elem_next;
    logic [LINK_W-1:0] prev_reg, prev_next;
    logic [CNT_W-1:0]  steps_reg, steps_next;
    logic              status_reg, status_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [7:0]        m_tdata_reg, m_tdata_next;

    lqar_wr_t          wr;
    logic [SLOT_W-1:0] rd_addr;
    logic [LINK_W-1:0] rd_data;

    logic [IDX_W-1:0]  s_elem;
    logic              s_elem_ok;
    logic [LINK_W-1:0] s_elem_link;
    logic              accept;
    logic              out_free;
    logic              head_empty;

    lqar_link_ram u_link_ram (
        .aclk    (aclk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_elem      = s_tdata[IDX_W-1:0];
    assign s_elem_ok   = 32'(s_elem) < CAPACITY;
    assign s_elem_link = LINK_W'(s_elem);
    assign s_tready    = (state_reg == ST_IDLE);
    assign accept      = s_tvalid && s_tready;
    assign out_free    = !m_tvalid_reg || m_tready;
    assign head_empty  = !slot_ok(head_reg);

    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        elem_next     = elem_reg;
        prev_next     = prev_reg;
        steps_next    = steps_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        wr            = '0;
        rd_addr       = SLOT_W'(head_reg);

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    elem_next  = s_elem_link;
                    prev_next  = head_reg;
                    steps_next = '0;
                    if (!s_elem_ok) begin
                        status_next = 1'b1;
                        state_next  = ST_RESP;
                    end else if (s_tuser == FUNC_APPEND) begin
                        status_next = 1'b0;
                        state_next  = ST_APP1;
                    end else if (head_empty) begin
                        status_next = 1'b1;
                        state_next  = ST_RESP;
                    end else if (head_reg == s_elem_link) begin
                        rd_addr    = SLOT_W'(s_elem);
                        state_next = ST_HREAD;
                    end else begin
                        rd_addr    = SLOT_W'(head_reg);
                        state_next = ST_WALK;
                    end
                end
            end
            ST_APP1: begin
                wr.we   = 1'b1;
                wr.addr = SLOT_W'(elem_reg);
                wr.data = NULL_LINK;
                if (head_empty) begin
                    head_next  = elem_reg;
                    tail_next  = elem_reg;
                    state_next = ST_RESP;
                end else if (slot_ok(tail_reg)) begin
                    state_next = ST_APP2;
                end else begin
                    tail_next  = elem_reg;
                    state_next = ST_RESP;
                end
            end
            ST_APP2: begin
                wr.we      = 1'b1;
                wr.addr    = SLOT_W'(tail_reg);
                wr.data    = elem_reg;
                tail_next  = elem_reg;
                state_next = ST_RESP;
            end
            ST_HREAD: begin
                head_next = rd_data;
                if (tail_reg == elem_reg) begin
                    tail_next = NULL_LINK;
                end
                wr.we       = 1'b1;
                wr.addr     = SLOT_W'(elem_reg);
                wr.data     = NULL_LINK;
                status_next = 1'b0;
                state_next  = ST_RESP;
            end
            ST_WALK: begin
                // rd_data is the link of prev_reg, i.e. the current slot
                if (steps_reg == CNT_W'(CAPACITY) || !slot_ok(rd_data)) begin
                    status_next = 1'b1;
                    state_next  = ST_RESP;
                end else if (rd_data == elem_reg) begin
                    rd_addr    = SLOT_W'(rd_data);
                    state_next = ST_FIX;
                end else begin
                    rd_addr    = SLOT_W'(rd_data);
                    prev_next  = rd_data;
                    steps_next = steps_reg + 1'b1;
                end
            end
            ST_FIX: begin
                wr.we   = 1'b1;
                wr.addr = SLOT_W'(prev_reg);
                wr.data = rd_data;
                if (tail_reg == elem_reg) begin
                    tail_next = prev_reg;
                end
                state_next = ST_FIX2;
            end
            ST_FIX2: begin
                wr.we       = 1'b1;
                wr.addr     = SLOT_W'(elem_reg);
                wr.data     = NULL_LINK;
                status_next = 1'b0;
                state_next  = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {head_empty ? IDX_W'(0) : IDX_W'(head_reg),
                                     head_empty, status_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_reg     <= NULL_LINK;
            tail_reg     <= NULL_LINK;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        elem_reg    <= elem_next;
        prev_reg    <= prev_next;
        steps_reg   <= steps_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg != ST_IDLE)
        else $error("word accepted but sequencer stayed idle");

    a_no_write_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK |-> !wr.we)
        else $error("link RAM written during walk");

    a_steps_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK |-> steps_reg <= CNT_W'(CAPACITY))
        else $error("walk step count past capacity");

    a_empty_head_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1]) |-> m_tdata[7:2] == 6'd0)
        else $error("empty queue reported with nonzero head");

    a_result_only_from_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && $rose(m_tvalid)) |-> $past(state_reg) == ST_RESP)
        else $error("result raised outside response state");

endmodule
